[src/esf_pkg.sv]
package esf_pkg;

   typedef enum logic [2:0] {
      MODE_NORMAL   = 3'd0,
      MODE_ESC      = 3'd1,
      MODE_CSI      = 3'd2,
      MODE_OSC      = 3'd3,
      MODE_ONE_MORE = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      KIND_PLAIN    = 3'd0,
      KIND_TWO      = 3'd1,
      KIND_ESC_ESC  = 3'd2,
      KIND_UNKNOWN  = 3'd3,
      KIND_CSI      = 3'd4,
      KIND_OSC      = 3'd5,
      KIND_THREE    = 3'd6,
      KIND_OVERFLOW = 3'd7
   } run_kind_type;

   // write port from the parser into the byte ring
   typedef struct packed {
      logic       en;
      logic [7:0] data;
   } ring_wr_type;

   localparam logic [7:0] BYTE_ESC      = 8'h1B;
   localparam logic [7:0] BYTE_BEL      = 8'h07;
   localparam logic [7:0] BYTE_BSLASH   = 8'h5C;
   localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
   localparam logic [7:0] BYTE_RBRACKET = 8'h5D;
   localparam logic [7:0] BYTE_SPACE    = 8'h20;
   localparam logic [7:0] BYTE_HASH     = 8'h23;
   localparam logic [7:0] BYTE_PERCENT  = 8'h25;
   localparam logic [7:0] CSI_FINAL_LO  = 8'h40;
   localparam logic [7:0] CSI_FINAL_HI  = 8'h7E;

   // digits, D E H M N c l m n r t = > <
   function automatic logic is_two_char_final(input logic [7:0] b);
      logic hit;
      hit = (b >= 8'h30) && (b <= 8'h39);
      unique case (b)
         8'h44, 8'h45, 8'h48, 8'h4D, 8'h4E,
         8'h63, 8'h6C, 8'h6D, 8'h6E, 8'h72, 8'h74,
         8'h3D, 8'h3E, 8'h3C: hit = 1'b1;
         default: ;
      endcase
      return hit;
   endfunction

   // space, charset designators ( ) * +, '#' and '%'
   function automatic logic is_one_more(input logic [7:0] b);
      return (b == BYTE_SPACE) || (b == 8'h28) || (b == 8'h29) || (b == 8'h2A) ||
             (b == 8'h2B) || (b == BYTE_HASH) || (b == BYTE_PERCENT);
   endfunction

endpackage

[src/escape_sequence_framer_unit.sv]
// Output: bytes read from the byte ring pass the s1 register and then the output register; a held
//   run starts once its final byte is accepted, then one byte per cycle while rsp_ready is high.
// Throughput: one input byte per cycle while the single-read-port byte ring (2 * HOLD_DEPTH
//   entries, rounded up to a power of two) and its 4-entry run queue are not full.
// Reset: synchronous, clears parser state, pointers and valids; ring contents are not cleared.
module escape_sequence_framer_unit #(
   parameter int HOLD_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic [2:0] rsp_run_kind,
   output logic       rsp_last_of_run
);
   import esf_pkg::*;

   localparam int LEN_W = $clog2(HOLD_DEPTH + 1);

   ring_wr_type      ring_wr;
   logic             ring_full;
   logic             desc_full;
   logic             desc_push;
   logic [LEN_W-1:0] push_len;
   logic [2:0]       push_kind;
   logic             desc_valid;
   logic             desc_pop;
   logic [LEN_W-1:0] head_len;
   logic [2:0]       head_kind;

   esf_front #(
      .HOLD_DEPTH (HOLD_DEPTH),
      .LEN_W      (LEN_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .ring_full   (ring_full),
      .desc_full   (desc_full),
      .ring_wr     (ring_wr),
      .desc_push   (desc_push),
      .desc_len    (push_len),
      .desc_kind   (push_kind)
   );

   esf_desc_fifo #(
      .LEN_W (LEN_W)
   ) u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_len  (push_len),
      .push_kind (push_kind),
      .full      (desc_full),
      .nonempty  (desc_valid),
      .pop       (desc_pop),
      .head_len  (head_len),
      .head_kind (head_kind)
   );

   esf_back #(
      .HOLD_DEPTH (HOLD_DEPTH),
      .LEN_W      (LEN_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .ring_wr         (ring_wr),
      .ring_full       (ring_full),
      .desc_valid      (desc_valid),
      .desc_len        (head_len),
      .desc_kind       (head_kind),
      .desc_pop        (desc_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_kind    (rsp_run_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

[src/esf_front.sv]
module esf_front #(
   parameter int HOLD_DEPTH = 64,
   parameter int LEN_W      = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   input  logic                 ring_full,
   input  logic                 desc_full,
   output esf_pkg::ring_wr_type ring_wr,
   output logic                 desc_push,
   output logic [LEN_W-1:0]     desc_len,
   output logic [2:0]           desc_kind
);
   import esf_pkg::*;

   mode_type         mode_ff, mode_in;
   logic [LEN_W-1:0] held_ff, held_in;
   logic             prev_esc_ff, prev_esc_in;

   logic             accept;
   logic             flush;
   logic             holding;
   run_kind_type     kind;
   logic [LEN_W-1:0] held_next;

   assign req_ready = !ring_full && !desc_full;
   assign accept    = req_valid && req_ready;
   assign held_next = held_ff + LEN_W'(1);

   // every accepted byte goes into the ring
   assign ring_wr.en   = accept;
   assign ring_wr.data = req_in_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_NORMAL;
         held_ff     <= '0;
         prev_esc_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         held_ff     <= held_in;
         prev_esc_ff <= prev_esc_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      held_in     = held_ff;
      prev_esc_in = prev_esc_ff;
      flush       = 1'b0;
      holding     = 1'b0;
      kind        = KIND_PLAIN;
      desc_push   = 1'b0;
      desc_len    = LEN_W'(1);
      if (accept) begin
         unique case (mode_ff)
            MODE_NORMAL: begin
               if (req_in_byte == BYTE_ESC) begin
                  mode_in     = MODE_ESC;
                  held_in     = LEN_W'(1);
                  prev_esc_in = 1'b0;
               end else begin
                  desc_push = 1'b1;
               end
            end
            MODE_ESC: begin
               holding = 1'b1;
               priority if (req_in_byte == BYTE_ESC) begin
                  flush = 1'b1;
                  kind  = KIND_ESC_ESC;
               end else if (is_two_char_final(req_in_byte)) begin
                  flush = 1'b1;
                  kind  = KIND_TWO;
               end else if (req_in_byte == BYTE_LBRACKET) begin
                  mode_in = MODE_CSI;
               end else if (req_in_byte == BYTE_RBRACKET) begin
                  mode_in     = MODE_OSC;
                  prev_esc_in = 1'b0;
               end else if (is_one_more(req_in_byte)) begin
                  mode_in = MODE_ONE_MORE;
               end else begin
                  flush = 1'b1;
                  kind  = KIND_UNKNOWN;
               end
            end
            MODE_CSI: begin
               holding = 1'b1;
               if (req_in_byte >= CSI_FINAL_LO && req_in_byte <= CSI_FINAL_HI) begin
                  flush = 1'b1;
                  kind  = KIND_CSI;
               end
            end
            MODE_OSC: begin
               holding = 1'b1;
               if (req_in_byte == BYTE_BEL ||
                   (prev_esc_ff && req_in_byte == BYTE_BSLASH)) begin
                  flush = 1'b1;
                  kind  = KIND_OSC;
               end else begin
                  prev_esc_in = (req_in_byte == BYTE_ESC);
               end
            end
            MODE_ONE_MORE: begin
               holding = 1'b1;
               flush   = 1'b1;
               kind    = KIND_THREE;
            end
            default: begin
               mode_in = MODE_NORMAL;
            end
         endcase

         if (holding && !flush && held_next >= LEN_W'(HOLD_DEPTH)) begin
            flush = 1'b1;
            kind  = KIND_OVERFLOW;
         end

         if (flush) begin
            desc_push   = 1'b1;
            desc_len    = held_next;
            mode_in     = MODE_NORMAL;
            held_in     = '0;
            prev_esc_in = 1'b0;
         end else if (holding) begin
            held_in = held_next;
         end
      end
   end

   assign desc_kind = kind;

endmodule

[src/esf_desc_fifo.sv]
module esf_desc_fifo #(
   parameter int LEN_W = 7
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [LEN_W-1:0] push_len,
   input  logic [2:0]       push_kind,
   output logic             full,
   output logic             nonempty,
   input  logic             pop,
   output logic [LEN_W-1:0] head_len,
   output logic [2:0]       head_kind
);
   import esf_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   logic [LEN_W-1:0] len_mem [DEPTH];
   logic [2:0]       kind_mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;

   assign full      = (count_ff == (AW+1)'(DEPTH));
   assign nonempty  = (count_ff != '0);
   assign head_len  = len_mem[rd_ptr_ff];
   assign head_kind = kind_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         len_mem[wr_ptr_ff]  <= push_len;
         kind_mem[wr_ptr_ff] <= push_kind;
      end
   end

endmodule

[src/esf_back.sv]
module esf_back #(
   parameter int HOLD_DEPTH = 64,
   parameter int LEN_W      = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  esf_pkg::ring_wr_type ring_wr,
   output logic                 ring_full,
   input  logic                 desc_valid,
   input  logic [LEN_W-1:0]     desc_len,
   input  logic [2:0]           desc_kind,
   output logic                 desc_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic [2:0]           rsp_run_kind,
   output logic                 rsp_last_of_run
);
   import esf_pkg::*;

   // twice the hold depth, so a finished run drains while the next one is held
   localparam int RING_AW    = $clog2(HOLD_DEPTH) + 1;
   localparam int RING_DEPTH = 2 ** RING_AW;

   logic [7:0]         ring_mem [RING_DEPTH];
   logic [RING_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RING_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RING_AW:0]   fill_ff, fill_in;

   logic               active_ff, active_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [2:0]         cur_kind_ff, cur_kind_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [7:0]         s1_data_ff;
   logic [2:0]         s1_kind_ff;
   logic               s1_last_ff;

   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_byte_ff;
   logic [2:0]         out_kind_ff;
   logic               out_last_ff;

   logic               out_free;
   logic               issue;
   logic [2:0]         issue_kind;
   logic               issue_last;

   assign ring_full = (fill_ff == (RING_AW+1)'(RING_DEPTH));
   assign out_free  = !out_valid_ff || rsp_ready;
   assign issue     = (active_ff || desc_valid) && (!s1_valid_ff || out_free);
   assign desc_pop  = issue && !active_ff;

   always_comb begin
      wr_ptr_in    = ring_wr.en ? wr_ptr_ff + RING_AW'(1) : wr_ptr_ff;
      rd_ptr_in    = issue ? rd_ptr_ff + RING_AW'(1) : rd_ptr_ff;
      fill_in      = fill_ff + (RING_AW+1)'(ring_wr.en) - (RING_AW+1)'(issue);
      active_in    = active_ff;
      left_in      = left_ff;
      cur_kind_in  = cur_kind_ff;
      issue_kind   = cur_kind_ff;
      issue_last   = (left_ff == LEN_W'(1));
      if (issue) begin
         if (active_ff) begin
            left_in   = left_ff - LEN_W'(1);
            active_in = (left_ff != LEN_W'(1));
         end else begin
            issue_kind  = desc_kind;
            issue_last  = (desc_len == LEN_W'(1));
            cur_kind_in = desc_kind;
            left_in     = desc_len - LEN_W'(1);
            active_in   = (desc_len != LEN_W'(1));
         end
      end
      if (issue) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      out_valid_in = out_free ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         active_ff    <= 1'b0;
         left_ff      <= '0;
         cur_kind_ff  <= KIND_PLAIN;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         active_ff    <= active_in;
         left_ff      <= left_in;
         cur_kind_ff  <= cur_kind_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_wr.en) begin
         ring_mem[wr_ptr_ff] <= ring_wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_data_ff <= ring_mem[rd_ptr_ff];
         s1_kind_ff <= issue_kind;
         s1_last_ff <= issue_last;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         out_byte_ff <= s1_data_ff;
         out_kind_ff <= s1_kind_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_run_kind    = out_kind_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import esf_pkg::*;

   localparam int HOLD_DEPTH  = 64;
   localparam int ITEM_COUNT  = 430;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [7:0]   data;
      run_kind_type kind;
      logic         last;
   } framed_byte_type;

   typedef struct {
      logic [7:0]   in_byte;
      logic         typed;
      logic [7:0]   out_byte;
      run_kind_type kind;
      logic         last;
   } stim_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic [2:0] rsp_run_kind;
   logic       rsp_last_of_run;

   // framer state as seen by the predictor
   mode_type   parse_mode;
   logic [7:0] held_bytes[HOLD_DEPTH];
   int         held_count;
   logic       prev_esc;

   framed_byte_type emitted[$];
   framed_byte_type expected_bytes[$];
   stim_row_type    directed_rows[$];

   int   error_count;
   int   items_sent;
   int   cycle_count;
   int   long_runs;
   logic idle_on;
   logic long_stall_req;

   escape_sequence_framer_unit #(.HOLD_DEPTH(HOLD_DEPTH)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_kind    (rsp_run_kind),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic is_short_final(input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      case (b)
         "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
         "D", "E", "H", "M", "N", "c", "l", "m", "n", "r", "t",
         "=", ">", "<": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic is_designator(input logic [7:0] b);
      logic hit;
      hit = 1'b0;
      case (b)
         " ", "(", ")", "*", "+", "#", "%": hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic void emit_byte(input framed_byte_type fb);
      emitted.insert(emitted.size(), fb);
   endfunction

   function automatic void expect_byte(input framed_byte_type fb);
      expected_bytes.insert(expected_bytes.size(), fb);
   endfunction

   function automatic void stash(input logic [7:0] b);
      if (held_count < HOLD_DEPTH) begin
         held_bytes[held_count] = b;
         held_count++;
      end
   endfunction

   function automatic void flush_run(input run_kind_type kind);
      framed_byte_type fb;
      for (int i = 0; i < held_count; i++) begin
         fb.data = held_bytes[i];
         fb.kind = kind;
         fb.last = (i == held_count - 1);
         emit_byte(fb);
      end
      held_count = 0;
      prev_esc   = 1'b0;
      parse_mode = MODE_NORMAL;
   endfunction

   // advance the framer by one byte; the bytes it releases land in emitted
   function automatic void frame_byte(input logic [7:0] b);
      framed_byte_type fb;
      emitted.delete();
      if (parse_mode == MODE_NORMAL) begin
         if (b == BYTE_ESC) begin
            held_count = 0;
            prev_esc   = 1'b0;
            stash(b);
            parse_mode = MODE_ESC;
         end else begin
            fb.data = b;
            fb.kind = KIND_PLAIN;
            fb.last = 1'b1;
            emit_byte(fb);
         end
         return;
      end
      stash(b);
      case (parse_mode)
         MODE_ESC: begin
            if (b == BYTE_ESC) flush_run(KIND_ESC_ESC);
            else if (is_short_final(b)) flush_run(KIND_TWO);
            else if (b == BYTE_LBRACKET) parse_mode = MODE_CSI;
            else if (b == BYTE_RBRACKET) begin
               parse_mode = MODE_OSC;
               prev_esc   = 1'b0;
            end else if (is_designator(b)) parse_mode = MODE_ONE_MORE;
            else flush_run(KIND_UNKNOWN);
         end
         MODE_CSI: begin
            if (b >= CSI_FINAL_LO && b <= CSI_FINAL_HI) flush_run(KIND_CSI);
         end
         MODE_OSC: begin
            if (b == BYTE_BEL || (prev_esc && b == BYTE_BSLASH)) flush_run(KIND_OSC);
            else prev_esc = (b == BYTE_ESC);
         end
         default: flush_run(KIND_THREE);
      endcase
      // a completed run has already cleared the count
      if (held_count >= HOLD_DEPTH) flush_run(KIND_OVERFLOW);
   endfunction

   // entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input framed_byte_type want = '0);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_in_byte = b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      frame_byte(b);
      if (typed) expect_byte(want);
      else foreach (emitted[i]) expect_byte(emitted[i]);
      items_sent++;
      @(negedge clock);
   endtask

   // long runs: CSI that overflows, CSI that completes exactly at full, OSC that overflows
   task automatic send_long_run(input int variant);
      send_byte(BYTE_ESC);
      send_byte(variant == 2 ? BYTE_RBRACKET : BYTE_LBRACKET);
      for (int i = 0; i < HOLD_DEPTH - 3; i++) begin
         if (variant == 2) send_byte(8'($urandom_range(8'h20, 8'h7E)));
         else send_byte(8'($urandom_range(8'h30, 8'h3F)));
      end
      if (variant == 1) send_byte(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
      else if (variant == 2) send_byte(8'($urandom_range(8'h20, 8'h7E)));
      else send_byte(8'($urandom_range(8'h30, 8'h3F)));
   endtask

   task automatic send_sequence();
      int         pick;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         do b = 8'($urandom_range(0, 255)); while (b == BYTE_ESC);
         send_byte(b);
      end else if (pick < 22) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 34) begin
         do b = 8'($urandom_range(8'h30, 8'h74)); while (!is_short_final(b));
         send_byte(BYTE_ESC);
         send_byte(b);
      end else if (pick < 39) begin
         send_byte(BYTE_ESC);
         send_byte(BYTE_ESC);
      end else if (pick < 46) begin
         do b = 8'($urandom_range(0, 255));
         while (b == BYTE_ESC || b == BYTE_LBRACKET || b == BYTE_RBRACKET ||
                is_short_final(b) || is_designator(b));
         send_byte(BYTE_ESC);
         send_byte(b);
      end else if (pick < 63) begin
         send_byte(BYTE_ESC);
         send_byte(BYTE_LBRACKET);
         n = $urandom_range(0, 6);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) != 0) b = 8'($urandom_range(8'h30, 8'h3F));
            else do b = 8'($urandom_range(0, 255)); while (b >= 8'h40 && b <= 8'h7E);
            send_byte(b);
         end
         send_byte(8'($urandom_range(CSI_FINAL_LO, CSI_FINAL_HI)));
      end else if (pick < 78) begin
         send_byte(BYTE_ESC);
         send_byte(BYTE_RBRACKET);
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) != 0) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            else send_byte(8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 1) == 0) send_byte(BYTE_BEL);
         else begin
            send_byte(BYTE_ESC);
            send_byte(BYTE_BSLASH);
         end
      end else if (pick < 90) begin
         do b = 8'($urandom_range(8'h20, 8'h2B)); while (!is_designator(b));
         send_byte(BYTE_ESC);
         send_byte(b);
         send_byte(8'($urandom_range(0, 255)));
      end else begin
         // broken: ESC and one random byte, whatever follows decides the rest
         send_byte(BYTE_ESC);
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   always @(posedge clock) begin
      framed_byte_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected byte %h kind %0d last %b", $time,
                     rsp_out_byte, rsp_run_kind, rsp_last_of_run);
            error_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_out_byte !== want.data) begin
               $display("%0t: out_byte expected %h actual %h", $time, want.data, rsp_out_byte);
               error_count++;
            end
            if (rsp_run_kind !== want.kind) begin
               $display("%0t: run_kind expected %0d actual %0d", $time, want.kind,
                        rsp_run_kind);
               error_count++;
            end
            if (rsp_last_of_run !== want.last) begin
               $display("%0t: last_of_run expected %b actual %b", $time, want.last,
                        rsp_last_of_run);
               error_count++;
            end
         end
      end
   end

   // receiver side: random stalls, one long hold-off on request
   initial begin
      int hold_cycles;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (long_stall_req) begin
            rsp_ready   = 1'b0;
            hold_cycles = 0;
            while (hold_cycles < LONG_HOLD) begin
               @(negedge clock);
               hold_cycles++;
            end
            long_stall_req = 1'b0;
            rsp_ready      = 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clock);
            rsp_ready = 1'b1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** escape_sequence_framer_unit: FAILED **");
      $finish;
   end

   initial begin
      logic            stall_done;
      logic            pause_done;
      framed_byte_type want;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      error_count    = 0;
      items_sent     = 0;
      long_runs      = 0;
      idle_on        = 1'b1;
      long_stall_req = 1'b0;
      stall_done     = 1'b0;
      pause_done     = 1'b0;
      parse_mode     = MODE_NORMAL;
      held_count     = 0;
      prev_esc       = 1'b0;

      directed_rows = '{
         '{8'h00,         1'b1, 8'h00, KIND_PLAIN, 1'b1},
         '{8'hFF,         1'b1, 8'hFF, KIND_PLAIN, 1'b1},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"D",           1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"z",           1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_LBRACKET, 1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"1",           1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"m",           1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_RBRACKET, 1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"0",           1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_BEL,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         // OSC closed by ESC backslash held inside the body
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_RBRACKET, 1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_BSLASH,   1'b0, 8'h00, KIND_PLAIN, 1'b0},
         // space introducer: one more byte, emitted once
         '{BYTE_ESC,      1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{BYTE_SPACE,    1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"F",           1'b0, 8'h00, KIND_PLAIN, 1'b0},
         '{"A",           1'b1, "A",   KIND_PLAIN, 1'b1}
      };

      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         want.data = directed_rows[i].out_byte;
         want.kind = directed_rows[i].kind;
         want.last = directed_rows[i].last;
         send_byte(directed_rows[i].in_byte, directed_rows[i].typed, want);
      end

      while (items_sent < ITEM_COUNT) begin
         if (!stall_done && items_sent >= 150) begin
            long_stall_req = 1'b1;
            stall_done     = 1'b1;
         end
         if (!pause_done && items_sent >= 300) begin
            req_valid = 1'b0;
            while (expected_bytes.size() != 0) @(negedge clock);
            pause_done = 1'b1;
         end
         if (items_sent >= 370) idle_on = 1'b0;
         if (long_runs < 3 && items_sent >= 90 + long_runs * 70) begin
            send_long_run(long_runs);
            long_runs++;
         end else begin
            send_sequence();
         end
      end
      req_valid = 1'b0;

      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) $display("** escape_sequence_framer_unit: PASSED **");
      else $display("** escape_sequence_framer_unit: FAILED **");
      $finish;
   end

endmodule
